[hw/rtl/assert_macros.svh]
// assertion helpers for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that holds on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/pts_pkg.sv]
// ----------------------------------------------------------------------------
// pts_pkg
// shared constants for the pointer trail sampler
// ----------------------------------------------------------------------------
package pts_pkg;

  localparam int MaxSamplesDef = 64;

  localparam logic [19:0] SpeedMax  = 20'hFFFFF;
  localparam logic [7:0]  WeightNew = 8'd118;
  localparam logic [7:0]  WeightOld = 8'd138;

  // configuration register indexes
  localparam logic [1:0] RegActSpeed = 2'd0;
  localparam logic [1:0] RegDuration = 2'd1;
  localparam logic [1:0] RegMinStep  = 2'd2;
  localparam logic [1:0] RegMaxJump  = 2'd3;

  // input commands
  localparam logic CmdMove = 1'b0;
  localparam logic CmdTick = 1'b1;

endpackage

[hw/rtl/pointer_trail_sampler.sv]
// ----------------------------------------------------------------------------
// pointer_trail_sampler
// records pointer samples into a ring with speed filtering and expiry
// ----------------------------------------------------------------------------
// Usage: one request per pointer move or time tick enters on the in_ stream
// and yields exactly one result on the out_ stream. in_tdata packs
// new_x, new_y, old_x, old_y, now_ms (lowest bits first), in_tuser packs
// cmd then suppressed. out_tdata packs sample_count, speed_now, pushed,
// cleared, trail_active.
// Sequence: a move runs a 17-step square root (two radicand bits per step),
// a load step and a 27-step restoring divider, then the filter and push
// steps; the ring time memory is then read once per prune step (one read
// port, registered read). A tick goes straight to the prune steps; a jump or
// a suppressed request goes straight to the result. One request is worked on
// at a time; in_tready is high when the block is idle, so a new request is
// taken only once the last one has reached the output register.
// The result waits in the output register while out_tready is low; the
// next request is then already accepted and computed, and holds until the
// register drains.
// Reset clears the ring pointers, filter and configuration to defaults; the
// sample memory itself is not cleared, only written entries are read.
// ----------------------------------------------------------------------------
module pointer_trail_sampler #(
  parameter int MAX_SAMPLES = pts_pkg::MaxSamplesDef
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // new_x[15:0], new_y[31:16], old_x[47:32], old_y[63:48], now_ms[95:64]
  input  logic [95:0]  in_tdata,
  // cmd[0], suppressed[1]
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // sample_count[6:0], speed_now[26:7], pushed[28:27], cleared[29],
  // trail_active[30]
  output logic [31:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_wdata
);
  import pts_pkg::*;

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam logic [CW-1:0] Depth = CW'(MAX_SAMPLES);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_DIV, S_FILT, S_PUSH0, S_PUSH1, S_PRD, S_PCHK, S_DONE
  } state_t;

  state_t state_r;

  // configuration
  logic [10:0] act_r;
  logic [9:0]  dur_r;
  logic [7:0]  mstep_r;
  logic [15:0] mjump_r;

  // trail state
  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [19:0]   smooth_r;
  logic [15:0]   lx_r, ly_r;
  logic [31:0]   lt_r;
  logic          have_r;

  // request latch
  logic [15:0] nx_r, ny_r;
  logic [31:0] now_r, el_r;
  logic        sup_r;
  logic [33:0] d2_r;
  logic        step_ok_r;
  logic [1:0]  pushed_r;
  logic        clr_r;

  // iterative units
  logic [33:0] rem_r;
  logic [16:0] root_r;
  logic [5:0]  cnt_r;
  logic [26:0] dnum_r;
  logic [35:0] drem_r;
  logic [26:0] quo_r;

  // output register
  logic        ov_r;
  logic [31:0] od_r;

  // sample memory (position and speed kept, only time is read back)
  logic [15:0] mem_x [MAX_SAMPLES];
  logic [15:0] mem_y [MAX_SAMPLES];
  logic [31:0] mem_t [MAX_SAMPLES];
  logic [19:0] mem_s [MAX_SAMPLES];
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   wx, wy;
  logic [31:0]   wt, rt_r;
  logic [19:0]   ws;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[waddr] <= wx;
      mem_y[waddr] <= wy;
      mem_t[waddr] <= wt;
      mem_s[waddr] <= ws;
    end
    rt_r <= mem_t[raddr];
  end

  function automatic logic [AW-1:0] wrap(input logic [AW:0] v);
    logic [AW:0] r;
    r = (v >= (AW+1)'(MAX_SAMPLES)) ? v - (AW+1)'(MAX_SAMPLES) : v;
    return r[AW-1:0];
  endfunction

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign raddr      = head_r;

  // field decode
  logic signed [15:0] i_nx, i_ny, i_ox, i_oy;
  logic [31:0] i_now;
  assign i_nx  = in_tdata[15:0];
  assign i_ny  = in_tdata[31:16];
  assign i_ox  = in_tdata[47:32];
  assign i_oy  = in_tdata[63:48];
  assign i_now = in_tdata[95:64];

  // squared distance from the effective last point
  logic signed [15:0] bx, by;
  logic signed [16:0] dx, dy;
  logic [33:0] d2;
  logic [31:0] bt, el0;
  logic [33:0] step2, jump2;
  assign bx  = have_r ? lx_r : i_ox;
  assign by  = have_r ? ly_r : i_oy;
  assign bt  = have_r ? lt_r : i_now;
  assign dx  = 17'(i_nx) - 17'(bx);
  assign dy  = 17'(i_ny) - 17'(by);
  assign d2  = 34'(dx) * 34'(dx) + 34'(dy) * 34'(dy);
  assign el0 = i_now - bt;
  assign step2 = 34'(mstep_r) * 34'(mstep_r);
  assign jump2 = 34'(mjump_r) * 34'(mjump_r);

  // root step
  logic [35:0] rsh;
  logic [18:0] rtr;
  assign rsh = {rem_r, 2'b00} | 36'(d2_r[33:32]);
  assign rtr = {root_r, 2'b01};

  // divider step
  logic [36:0] dsh;
  logic [36:0] dvs;
  assign dsh = {drem_r, dnum_r[26]};
  assign dvs = {1'b0, el_r, 4'b0000};

  // filter
  logic [19:0] raw;
  logic [28:0] fsum;
  logic [20:0] fval;
  assign raw  = (|quo_r[26:20]) ? SpeedMax : quo_r[19:0];
  assign fsum = 29'(smooth_r) * 29'(WeightOld) + 29'(raw) * 29'(WeightNew) + 29'd128;
  assign fval = (smooth_r == '0) ? {1'b0, raw} : fsum[28:8];

  logic [31:0] age;
  assign age = now_r - rt_r;
  logic reached;
  assign reached = smooth_r >= 20'(act_r);

  // write port drive
  always_comb begin
    we = 1'b0;
    wx = nx_r; wy = ny_r; wt = now_r; ws = smooth_r;
    waddr = wrap({1'b0, head_r} + (AW+1)'(count_r == Depth ? '0 : count_r));
    if (state_r == S_PUSH0 && step_ok_r && count_r == '0 && reached) begin
      we = 1'b1; wx = lx_r; wy = ly_r; wt = now_r - el_r;
      waddr = head_r;
    end else if (state_r == S_PUSH1 && step_ok_r && (count_r != '0 || reached)) begin
      we = 1'b1;
      if (count_r == Depth) waddr = head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      act_r    <= 11'd320;
      dur_r    <= 10'd330;
      mstep_r  <= 8'd16;
      mjump_r  <= 16'd6400;
      head_r   <= '0;
      count_r  <= '0;
      smooth_r <= '0;
      lx_r     <= '0;
      ly_r     <= '0;
      lt_r     <= '0;
      have_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_we) begin
        case (cfg_index)
          RegActSpeed: act_r   <= cfg_wdata[10:0];
          RegDuration: dur_r   <= cfg_wdata[9:0];
          RegMinStep:  mstep_r <= cfg_wdata[7:0];
          RegMaxJump:  mjump_r <= cfg_wdata;
          default: ;
        endcase
      end

      // output register valid
      if (state_r == S_DONE && (!ov_r || out_tready)) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            nx_r <= i_nx; ny_r <= i_ny; now_r <= i_now;
            sup_r <= in_tuser[1];
            pushed_r <= 2'd0;
            el_r <= (el0 == '0) ? 32'd1 : el0;
            d2_r <= d2;
            step_ok_r <= d2 >= step2;
            if (in_tuser[1]) begin
              head_r <= '0; count_r <= '0; smooth_r <= '0; have_r <= 1'b0;
              clr_r <= 1'b1;
              state_r <= S_DONE;
            end else if (in_tuser[0] == CmdTick) begin
              clr_r <= 1'b0;
              state_r <= S_PRD;
            end else if (d2 > jump2) begin
              head_r <= '0; count_r <= '0; smooth_r <= '0;
              have_r <= 1'b1; lx_r <= i_nx; ly_r <= i_ny; lt_r <= i_now;
              clr_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              clr_r <= 1'b0;
              lx_r <= bx; ly_r <= by; have_r <= 1'b1;
              rem_r <= '0; root_r <= '0; cnt_r <= 6'd17;
              state_r <= S_SQRT;
            end
          end
        end
        // two bits of the radicand per cycle
        S_SQRT: begin
          d2_r <= {d2_r[31:0], 2'b00};
          if (rsh >= 36'(rtr)) begin
            rem_r  <= 34'(rsh - 36'(rtr));
            root_r <= {root_r[15:0], 1'b1};
          end else begin
            rem_r  <= rsh[33:0];
            root_r <= {root_r[15:0], 1'b0};
          end
          if (cnt_r == 6'd1) begin
            state_r <= S_DIV;
            cnt_r <= 6'd28;
          end else begin
            cnt_r <= cnt_r - 6'd1;
          end
        end
        // load dist*1000, then one quotient bit per cycle
        S_DIV: begin
          if (cnt_r == 6'd28) begin
            dnum_r <= 27'(root_r) * 27'd1000;
            drem_r <= '0;
            quo_r  <= '0;
            cnt_r  <= 6'd27;
          end else begin
            dnum_r <= {dnum_r[25:0], 1'b0};
            if (dsh >= dvs) begin
              drem_r <= 36'(dsh - dvs);
              quo_r  <= {quo_r[25:0], 1'b1};
            end else begin
              drem_r <= dsh[35:0];
              quo_r  <= {quo_r[25:0], 1'b0};
            end
            if (cnt_r == 6'd1) state_r <= S_FILT;
            else cnt_r <= cnt_r - 6'd1;
          end
        end
        S_FILT: begin
          smooth_r <= fval[20] ? SpeedMax : fval[19:0];
          state_r <= S_PUSH0;
        end
        S_PUSH0: begin
          if (we) begin
            count_r <= count_r + CW'(1);
            pushed_r <= 2'd1;
          end
          state_r <= S_PUSH1;
        end
        S_PUSH1: begin
          if (we) begin
            pushed_r <= pushed_r + 2'd1;
            if (count_r == Depth) head_r <= wrap({1'b0, head_r} + (AW+1)'(1));
            else count_r <= count_r + CW'(1);
          end
          lx_r <= nx_r; ly_r <= ny_r; lt_r <= now_r;
          state_r <= S_PRD;
        end
        // memory read of the oldest sample time
        S_PRD: state_r <= S_PCHK;
        S_PCHK: begin
          if (count_r != '0 && age > 32'(dur_r)) begin
            head_r  <= wrap({1'b0, head_r} + (AW+1)'(1));
            count_r <= count_r - CW'(1);
            state_r <= S_PRD;
          end else begin
            if (count_r == CW'(1) && age > 32'(dur_r[9:1])) begin
              head_r <= '0; count_r <= '0; clr_r <= 1'b1;
            end
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ov_r || out_tready) begin
            od_r <= {1'b0, (!sup_r && count_r >= CW'(2)), clr_r, pushed_r,
                     smooth_r, 7'(count_r)};
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_count_range, clk, rst_n, count_r <= Depth, "ring count over depth")
  `ASSERT_CLK(a_busy_ready, clk, rst_n, (state_r != S_IDLE) |-> !in_tready, "ready while busy")
  `ASSERT_CLK(a_out_hold, clk, rst_n, (ov_r && !out_tready) |=> (ov_r && $stable(od_r)), "result lost")
  `ASSERT_CLK(a_push_lim, clk, rst_n, (state_r == S_DONE) |-> (pushed_r != 2'd3), "pushed overflow")

endmodule

[tb/sv/pointer_trail_sampler_test.sv]
// ----------------------------------------------------------------------------
// pointer_trail_sampler_test
// checks the pointer trail sampler against a local model of its ring,
// speed filter and expiry, with random idling on both streams and
// register changes between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pointer_trail_sampler_test;
  import pts_pkg::*;

  localparam int RingDepth   = MaxSamplesDef;
  localparam int WatchLimit  = 20000;
  localparam int SettleCycles = 400;

  typedef struct packed {
    logic        cmd;
    logic        suppressed;
    logic [15:0] new_x;
    logic [15:0] new_y;
    logic [15:0] old_x;
    logic [15:0] old_y;
    logic [31:0] now_ms;
  } move_req_t;

  // highest field first so the lowest bits hold sample_count
  typedef struct packed {
    logic        trail_active;
    logic        cleared;
    logic [1:0]  pushed;
    logic [19:0] speed_now;
    logic [6:0]  sample_count;
  } trail_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  pointer_trail_sampler uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #1;
    clk = 1'b1; #1;
  end

  // predictor state
  logic [10:0] act_speed;
  logic [9:0]  duration;
  logic [7:0]  min_step;
  logic [15:0] max_jump;
  logic [15:0] trail_x [RingDepth];
  logic [15:0] trail_y [RingDepth];
  logic [31:0] trail_t [RingDepth];
  int          trail_head;
  int          trail_count;
  logic [19:0] filt_speed;
  logic signed [15:0] prev_x, prev_y;
  logic [31:0] prev_t;
  logic        prev_valid;

  move_req_t  pending_reqs [$];
  trail_res_t expected_results [$];
  int  errors;
  int  idle_cycles;
  bit  stim_done;

  function automatic void add_req(input move_req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  function automatic void add_result(input trail_res_t r);
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function automatic void clear_trail();
    trail_head = 0;
    trail_count = 0;
    filt_speed = '0;
    prev_valid = 1'b0;
  endfunction

  function automatic void append_sample(input logic [15:0] x, input logic [15:0] y,
                                        input logic [31:0] t);
    int i;
    if (trail_count >= RingDepth) begin
      trail_head = (trail_head + 1) % RingDepth;
      trail_count--;
    end
    i = (trail_head + trail_count) % RingDepth;
    trail_x[i] = x;
    trail_y[i] = y;
    trail_t[i] = t;
    trail_count++;
  endfunction

  // drop expired samples; returns 1 when a lone half-aged sample clears
  function automatic bit expire_samples(input logic [31:0] now);
    logic [31:0] age;
    while (trail_count > 0) begin
      age = now - trail_t[trail_head];
      if (age <= 32'(duration)) break;
      trail_head = (trail_head + 1) % RingDepth;
      trail_count--;
    end
    if (trail_count == 1) begin
      age = now - trail_t[trail_head];
      if (age > 32'(duration >> 1)) begin
        trail_head = 0;
        trail_count = 0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic trail_res_t predict_trail(input move_req_t r);
    trail_res_t res;
    longint signed dx, dy;
    longint unsigned d2, jump2, step2, root_dist, raw, mix;
    logic [31:0] elapsed;
    bit reached;
    res = '0;
    if (r.suppressed) begin
      clear_trail();
      res.cleared = 1'b1;
    end else if (r.cmd == CmdTick) begin
      res.cleared = expire_samples(r.now_ms);
    end else begin
      if (!prev_valid) begin
        prev_x = r.old_x;
        prev_y = r.old_y;
        prev_t = r.now_ms;
        prev_valid = 1'b1;
      end
      dx = longint'($signed(r.new_x)) - longint'(prev_x);
      dy = longint'($signed(r.new_y)) - longint'(prev_y);
      d2 = dx * dx + dy * dy;
      jump2 = longint'(max_jump) * longint'(max_jump);
      step2 = longint'(min_step) * longint'(min_step);
      elapsed = r.now_ms - prev_t;
      if (elapsed == 0) elapsed = 1;
      if (d2 > jump2) begin
        clear_trail();
        res.cleared = 1'b1;
      end else begin
        root_dist = int_sqrt(d2);
        raw = (root_dist * 1000) / (longint'(elapsed) * 16);
        if (raw > longint'(SpeedMax)) raw = longint'(SpeedMax);
        if (filt_speed == 0) begin
          mix = raw;
        end else begin
          mix = (longint'(filt_speed) * longint'(WeightOld)
                 + raw * longint'(WeightNew) + 128) >> 8;
        end
        if (mix > longint'(SpeedMax)) mix = longint'(SpeedMax);
        filt_speed = 20'(mix);
        if (d2 >= step2) begin
          reached = filt_speed >= 20'(act_speed);
          if (trail_count == 0 && reached) begin
            append_sample(prev_x, prev_y, r.now_ms - elapsed);
            res.pushed++;
          end
          if (trail_count != 0 || reached) begin
            append_sample(r.new_x, r.new_y, r.now_ms);
            res.pushed++;
          end
        end
        res.cleared = expire_samples(r.now_ms);
      end
      // jump and normal path both record the new position
      prev_valid = 1'b1;
      prev_x = r.new_x;
      prev_y = r.new_y;
      prev_t = r.now_ms;
    end
    res.sample_count = 7'(trail_count);
    res.speed_now = filt_speed;
    res.trail_active = !r.suppressed && trail_count >= 2;
    return res;
  endfunction

  // driver: one request from the queue at a time, random gap before each
  int send_gap;
  always @(posedge clk) begin
    int gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      send_gap <= $urandom_range(0, 8);
    end else if (in_tvalid && in_tready) begin
      add_result(predict_trail(pending_reqs[0]));
      pending_reqs.delete(0);
      gap = $urandom_range(0, 8);
      send_gap <= gap;
      if (pending_reqs.size() > 0 && gap == 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_reqs[0].now_ms, pending_reqs[0].old_y,
                     pending_reqs[0].old_x, pending_reqs[0].new_y, pending_reqs[0].new_x};
        in_tuser <= {pending_reqs[0].suppressed, pending_reqs[0].cmd};
      end else begin
        in_tvalid <= 1'b0;
      end
    end else if (!in_tvalid) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tdata <= {pending_reqs[0].now_ms, pending_reqs[0].old_y,
                     pending_reqs[0].old_x, pending_reqs[0].new_y, pending_reqs[0].new_x};
        in_tuser <= {pending_reqs[0].suppressed, pending_reqs[0].cmd};
      end
    end
  end

  // monitor: random stall before each result, compare with oldest prediction
  int recv_gap;
  always @(posedge clk) begin
    trail_res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap <= $urandom_range(0, 8);
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[30:0];
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: %h", out_tdata);
          errors++;
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got.sample_count !== want.sample_count) begin
            $error("sample_count exp %0d got %0d", want.sample_count, got.sample_count);
            errors++;
          end
          if (got.speed_now !== want.speed_now) begin
            $error("speed_now exp %0d got %0d", want.speed_now, got.speed_now);
            errors++;
          end
          if (got.pushed !== want.pushed) begin
            $error("pushed exp %0d got %0d", want.pushed, got.pushed);
            errors++;
          end
          if (got.cleared !== want.cleared) begin
            $error("cleared exp %0d got %0d", want.cleared, got.cleared);
            errors++;
          end
          if (got.trail_active !== want.trail_active) begin
            $error("trail_active exp %0d got %0d", want.trail_active, got.trail_active);
            errors++;
          end
        end
      end
      if (out_tready && !(out_tvalid)) begin
        out_tready <= 1'b1;
      end else if (out_tready) begin
        recv_gap <= $urandom_range(0, 8);
        out_tready <= ($urandom_range(0, 3) == 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (!stim_done) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegActSpeed: act_speed = val[10:0];
      RegDuration: duration = val[9:0];
      RegMinStep:  min_step = val[7:0];
      RegMaxJump:  max_jump = val;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || in_tvalid)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic move_req_t make_req(input logic cmd, input logic sup,
      input logic [15:0] nx, input logic [15:0] ny, input logic [15:0] ox,
      input logic [15:0] oy, input logic [31:0] t);
    move_req_t r;
    r.cmd = cmd; r.suppressed = sup;
    r.new_x = nx; r.new_y = ny; r.old_x = ox; r.old_y = oy; r.now_ms = t;
    return r;
  endfunction

  // random-step moves in strokes, with ticks, suppressed and random requests
  task automatic queue_stroke(inout logic [31:0] clock_ms, input int len);
    logic [15:0] px, py;
    int step_max;
    px = 16'($urandom);
    py = 16'($urandom);
    step_max = $urandom_range(0, 3) == 0 ? 2000 : 300;
    for (int i = 0; i < len; i++) begin
      clock_ms += $urandom_range(0, 3) == 0 ? $urandom_range(0, 400) : $urandom_range(0, 20);
      case ($urandom_range(0, 19))
        0: add_req(make_req(CmdMove, 1'b1, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), clock_ms));
        1, 2: add_req(make_req(CmdTick, 1'b0, 16'($urandom), 16'($urandom),
                               16'($urandom), 16'($urandom), clock_ms));
        3: add_req(make_req(1'($urandom), 1'($urandom), 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), $urandom));
        default: begin
          px += 16'($urandom_range(0, 2 * step_max) - step_max);
          py += 16'($urandom_range(0, 2 * step_max) - step_max);
          add_req(make_req(CmdMove, 1'b0, px, py, px - 16'd40, py + 16'd8, clock_ms));
        end
      endcase
    end
  endtask

  initial begin
    logic [31:0] clock_ms;
    errors = 0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegActSpeed;
    cfg_wdata = '0;
    act_speed = 11'd320;
    duration = 10'd330;
    min_step = 8'd16;
    max_jump = 16'd6400;
    clear_trail();
    prev_x = '0; prev_y = '0; prev_t = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, jump, time wrap, suppression, ticks, min step
    add_req(make_req(CmdMove, 1'b0, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 32'd0));
    add_req(make_req(CmdMove, 1'b0, 16'h8000, 16'h8000, 16'd0, 16'd0, 32'hFFFF_FFFF));
    add_req(make_req(CmdMove, 1'b0, 16'h8010, 16'h8000, 16'd0, 16'd0, 32'hFFFF_FFFF));
    add_req(make_req(CmdMove, 1'b0, 16'h8400, 16'h8000, 16'd0, 16'd0, 32'h0000_0004));
    add_req(make_req(CmdMove, 1'b0, 16'h8800, 16'h8100, 16'd0, 16'd0, 32'h0000_000A));
    add_req(make_req(CmdMove, 1'b0, 16'h8C00, 16'h8200, 16'd0, 16'd0, 32'h0000_0010));
    add_req(make_req(CmdTick, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0020));
    add_req(make_req(CmdTick, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_00B0));
    add_req(make_req(CmdTick, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'h0000_0200));
    add_req(make_req(CmdMove, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     32'hFFFF_FFFF));
    add_req(make_req(CmdTick, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 32'd0));
    add_req(make_req(CmdMove, 1'b0, 16'h0100, 16'd0, 16'd0, 16'd0, 32'd100));
    add_req(make_req(CmdMove, 1'b0, 16'h0100, 16'd0, 16'd0, 16'd0, 32'd100));
    add_req(make_req(CmdMove, 1'b0, 16'h0500, 16'd0, 16'd0, 16'd0, 32'd90));
    add_req(make_req(CmdTick, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 32'd50));
    wait_drained();

    // phases over register settings, extremes included
    clock_ms = $urandom;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin
          write_reg(RegActSpeed, 16'd100); write_reg(RegDuration, 16'd650);
          write_reg(RegMinStep, 16'd0); write_reg(RegMaxJump, 16'd65535);
        end
        1: begin
          write_reg(RegActSpeed, 16'd1600); write_reg(RegDuration, 16'd120);
          write_reg(RegMinStep, 16'd255); write_reg(RegMaxJump, 16'd0);
        end
        2: begin
          write_reg(RegActSpeed, 16'hFFFF); write_reg(RegDuration, 16'hFFFF);
          write_reg(RegMinStep, 16'hFFFF); write_reg(RegMaxJump, 16'd3000);
        end
        default: begin
          write_reg(RegActSpeed, 16'($urandom_range(100, 1600)));
          write_reg(RegDuration, 16'($urandom_range(120, 650)));
          write_reg(RegMinStep, 16'($urandom_range(0, 255)));
          write_reg(RegMaxJump, 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(500, 8000)));
        end
      endcase
      for (int s = 0; s < 8; s++) queue_stroke(clock_ms, $urandom_range(10, 40));
      wait_drained();
    end
    stim_done = 1'b1;
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[pointer_trail_sampler.f]
+incdir+hw/rtl
hw/rtl/pts_pkg.sv
hw/rtl/pointer_trail_sampler.sv
tb/sv/pointer_trail_sampler_test.sv
